### hw/rtl/ppa_pkg.sv
// Shared types, constants and the page count function of the page pool allocator.
`default_nettype none

package ppa_pkg;

    localparam int DEF_MAX_PAGES = 64;
    localparam int DEF_PROCS     = 16;
    localparam int SLOTS         = 8;
    localparam int SLOT_W        = 3;
    localparam int CNT_W         = 4;
    localparam int PAGE_W        = 8;
    localparam int TOP_W         = 16;
    localparam int KB_W          = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_ALLOC  = 3'd1,
        ACT_FREE   = 3'd2,
        ACT_RESIZE = 3'd3,
        ACT_READ   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NOMEM    = 2'd1,
        STS_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_PROG_TOP     = 3'd0,
        CFG_LOW_BANK     = 3'd1,
        CFG_INVALID_PAGE = 3'd2,
        CFG_SUPERVISOR   = 3'd3,
        CFG_TOTAL_MEM    = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [2:0]        action;
        logic [3:0]        process;
        logic [PAGE_W-1:0] page;
        logic [TOP_W-1:0]  new_top;
        logic [TOP_W-1:0]  old_top;
        logic [SLOT_W-1:0] slot;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [PAGE_W-1:0] slot_page;
        logic [6:0]        free_count;
        logic [KB_W-1:0]   mem_used_kb;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CHECK,
        S_LAST,
        S_ISSUE,
        S_STEP,
        S_RSLOT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic check;
        logic cap_last;
        logic step;
        logic cap_slot;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic go_done;
        logic go_read;
        logic go_last;
        logic loop_end;
        logic out_free;
    } t_sts;

    // Number of 8K pages a process needs for a given top address, clamped at zero.
    function automatic logic [CNT_W-1:0] f_pages(
        input logic [TOP_W-1:0] top,
        input logic [TOP_W-1:0] prog_top,
        input logic [2:0]       low_bank
    );
        logic [TOP_W-1:0] v;
        logic [CNT_W:0]   n;
        v = top - prog_top - TOP_W'(1);
        n = (CNT_W+1)'(v[TOP_W-1 -: 3]) + (CNT_W+1)'(1) - (CNT_W+1)'(low_bank);
        f_pages = n[CNT_W] ? '0 : n[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ppa_ram.sv
// Generic single write port RAM with one registered read port.
`default_nettype none

module ppa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/ppa_datapath.sv
// Datapath: configuration registers, free page stack, bank table and result register.
`default_nettype none

module ppa_datapath
    import ppa_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES,
    parameter int PROCS     = DEF_PROCS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire t_in_item              i_in_item,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output t_out_item                  o_out_item
);

    localparam int SAW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int FTW    = $clog2(MAX_PAGES + 1);
    localparam int PW     = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int TDEPTH = PROCS * SLOTS;
    localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int CW     = (FTW > CNT_W) ? FTW : CNT_W;
    localparam int MW     = ((FTW + 3 > KB_W) ? FTW + 3 : KB_W) + 1;

    // Configuration.
    logic [TOP_W-1:0]  r_prog_top;
    logic [2:0]        r_low_bank;
    logic [PAGE_W-1:0] r_invalid_page;
    logic              r_supervisor;
    logic [KB_W-1:0]   r_total_mem;

    // Item context.
    t_in_item          r_item;
    logic [CNT_W-1:0]  r_want;
    logic [CNT_W-1:0]  r_have;
    logic [CNT_W-1:0]  r_used;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_end;
    logic [PAGE_W-1:0] r_last;
    logic [1:0]        r_status;
    logic [PAGE_W-1:0] r_slot_page;
    logic [FTW-1:0]    r_free_top;
    logic [TDEPTH-1:0] r_tvld;
    logic              r_tvld_q;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic [CNT_W-1:0]  n_idx;
    logic [CNT_W-1:0]  n_end;
    logic [PAGE_W-1:0] n_last;
    logic [1:0]        n_status;

    logic              w_proc_ok;
    logic              w_add, w_alloc, w_free, w_resize, w_read;
    logic              w_shrink, w_grow;
    logic              w_alloc_short, w_grow_short;
    logic              w_push_req, w_push_ok, w_pop;
    logic [PAGE_W-1:0] w_push_data;
    logic              w_tbl_we;
    logic [PAGE_W-1:0] w_tbl_wdata;
    logic [TAW-1:0]    w_tbl_waddr;
    logic [TAW-1:0]    w_tbl_raddr;
    logic [SLOT_W-1:0] w_rslot;
    logic [PAGE_W-1:0] w_tbl_rdata;
    logic [PAGE_W-1:0] w_tdata;
    logic [PAGE_W-1:0] w_stk_rdata;
    logic [FTW-1:0]    w_ft_m1;
    logic [PAGE_W-1:0] w_fill;
    logic [MW-1:0]     w_free_kb;
    logic [MW-1:0]     w_total_kb;
    logic [KB_W-1:0]   w_used_kb;

    // Decode of the item in progress; table actions on a process beyond the table do nothing.
    assign w_proc_ok = (32'(r_item.process) < 32'(PROCS));

    always_comb begin
        w_add    = 1'b0;
        w_alloc  = 1'b0;
        w_free   = 1'b0;
        w_resize = 1'b0;
        w_read   = 1'b0;
        case (r_item.action)
            ACT_ADD:    w_add    = 1'b1;
            ACT_ALLOC:  w_alloc  = w_proc_ok;
            ACT_FREE:   w_free   = w_proc_ok;
            ACT_RESIZE: w_resize = w_proc_ok;
            ACT_READ:   w_read   = w_proc_ok;
            default:    ;
        endcase
    end

    assign w_shrink      = (r_want < r_have);
    assign w_grow        = (r_want > r_have);
    assign w_alloc_short = (CW'(r_want) > CW'(r_free_top));
    assign w_grow_short  = (CW'(r_want - r_have) > CW'(r_free_top));

    assign o_sts.go_done  = w_add || !(w_alloc || w_free || w_resize || w_read)
                          || (w_alloc && w_alloc_short)
                          || (w_resize && !w_shrink && !w_grow)
                          || (w_resize && w_grow && w_grow_short);
    assign o_sts.go_read  = w_read;
    assign o_sts.go_last  = w_resize && w_shrink;
    assign o_sts.loop_end = (r_idx == r_end);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // Table read data of an entry never written reads as zero.
    assign w_tdata = r_tvld_q ? w_tbl_rdata : '0;
    assign w_fill  = (r_supervisor || (r_idx == '0)) ? r_invalid_page : r_last;

    always_comb begin
        w_push_req  = 1'b0;
        w_push_data = r_item.page;
        w_pop       = 1'b0;
        w_tbl_we    = 1'b0;
        w_tbl_wdata = w_stk_rdata;
        n_idx       = r_idx;
        n_end       = r_end;
        n_last      = r_last;
        n_status    = r_status;
        if (i_cmd.check) begin
            if (w_add) begin
                w_push_req = 1'b1;
            end else if (w_alloc) begin
                n_idx = '0;
                n_end = r_used;
                if (w_alloc_short) begin
                    n_status = STS_NOMEM;
                end
            end else if (w_free) begin
                n_idx  = '0;
                n_end  = r_used;
                n_last = r_invalid_page;
            end else if (w_resize) begin
                if (w_shrink) begin
                    n_idx = r_want;
                    n_end = r_have;
                end else begin
                    n_idx = r_have;
                    n_end = r_want;
                    if (w_grow && w_grow_short) begin
                        n_status = STS_NOMEM;
                    end
                end
            end
        end else if (i_cmd.cap_last) begin
            n_last = w_tdata;
        end else if (i_cmd.step) begin
            n_idx = r_idx + CNT_W'(1);
            if (w_alloc) begin
                w_tbl_we = 1'b1;
                if (r_idx < r_want) begin
                    w_pop  = 1'b1;
                    n_last = w_stk_rdata;
                end else begin
                    w_tbl_wdata = w_fill;
                    n_last      = w_fill;
                end
            end else if (w_free) begin
                if ((w_tdata != r_invalid_page) && (w_tdata != r_last)) begin
                    n_last      = w_tdata;
                    w_push_req  = 1'b1;
                    w_push_data = w_tdata;
                end
            end else if (w_resize) begin
                w_tbl_we = 1'b1;
                if (w_shrink) begin
                    w_push_req  = 1'b1;
                    w_push_data = w_tdata;
                    w_tbl_wdata = r_last;
                end else begin
                    w_pop = 1'b1;
                end
            end
        end
        // A push onto a full pool drops the page and flags the item.
        if (w_push_req && !w_push_ok) begin
            n_status = STS_OVERFLOW;
        end
    end

    assign w_push_ok = w_push_req && (r_free_top != FTW'(MAX_PAGES));
    assign w_ft_m1   = r_free_top - FTW'(1);

    assign w_rslot     = (r_item.action == ACT_READ) ? r_item.slot
                       : (i_cmd.check ? (SLOT_W'(SLOTS - 1) - r_low_bank)
                                      : r_idx[SLOT_W-1:0]);
    assign w_tbl_raddr = TAW'({PW'(r_item.process), w_rslot});
    assign w_tbl_waddr = TAW'({PW'(r_item.process), r_idx[SLOT_W-1:0]});

    ppa_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (MAX_PAGES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_push_ok),
        .i_waddr (r_free_top[SAW-1:0]),
        .i_wdata (w_push_data),
        .i_raddr (w_ft_m1[SAW-1:0]),
        .o_rdata (w_stk_rdata)
    );

    ppa_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (TDEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tbl_we),
        .i_waddr (w_tbl_waddr),
        .i_wdata (w_tbl_wdata),
        .i_raddr (w_tbl_raddr),
        .o_rdata (w_tbl_rdata)
    );

    // Memory in use for the result.
    assign w_free_kb  = MW'(r_free_top) << 3;
    assign w_total_kb = MW'(r_total_mem);
    assign w_used_kb  = (w_free_kb >= w_total_kb) ? '0 : KB_W'(w_total_kb - w_free_kb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_top     <= 16'hE000;
            r_low_bank     <= '0;
            r_invalid_page <= 8'hFF;
            r_supervisor   <= 1'b0;
            r_total_mem    <= 16'd512;
            r_free_top     <= '0;
            r_tvld         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_PROG_TOP:     r_prog_top     <= i_cfg_data;
                    CFG_LOW_BANK:     r_low_bank     <= i_cfg_data[2:0];
                    CFG_INVALID_PAGE: r_invalid_page <= i_cfg_data[PAGE_W-1:0];
                    CFG_SUPERVISOR:   r_supervisor   <= i_cfg_data[0];
                    CFG_TOTAL_MEM:    r_total_mem    <= i_cfg_data;
                    default:          ;
                endcase
            end
            if (w_push_ok) begin
                r_free_top <= r_free_top + FTW'(1);
            end else if (w_pop) begin
                r_free_top <= w_ft_m1;
            end
            if (w_tbl_we) begin
                r_tvld[w_tbl_waddr] <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tvld_q <= r_tvld[w_tbl_raddr];
        r_idx    <= n_idx;
        r_end    <= n_end;
        r_last   <= n_last;
        if (i_cmd.load_in) begin
            r_item      <= i_in_item;
            r_status    <= STS_OK;
            r_slot_page <= '0;
        end else begin
            r_status    <= n_status;
        end
        if (i_cmd.prep) begin
            r_want <= f_pages(r_item.new_top, r_prog_top, r_low_bank);
            r_have <= f_pages(r_item.old_top, r_prog_top, r_low_bank);
            r_used <= CNT_W'(SLOTS) - CNT_W'(r_low_bank);
        end
        if (i_cmd.cap_slot) begin
            r_slot_page <= w_tdata;
        end
        if (i_cmd.load_out) begin
            r_out_item.status      <= r_status;
            r_out_item.slot_page   <= r_slot_page;
            r_out_item.free_count  <= 7'(r_free_top);
            r_out_item.mem_used_kb <= w_used_kb;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

### hw/rtl/ppa_ctrl.sv
// Controller: sequences one item through decode, the slot walk and the result register.
`default_nettype none

module ppa_ctrl
    import ppa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP:  n_state = S_CHECK;
            S_CHECK: begin
                if (i_sts.go_done) begin
                    n_state = S_DONE;
                end else if (i_sts.go_read) begin
                    n_state = S_RSLOT;
                end else if (i_sts.go_last) begin
                    n_state = S_LAST;
                end else begin
                    n_state = S_ISSUE;
                end
            end
            S_LAST:  n_state = S_ISSUE;
            S_ISSUE: n_state = i_sts.loop_end ? S_DONE : S_STEP;
            S_STEP:  n_state = S_ISSUE;
            S_RSLOT: n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_in = i_in_valid;
            end
            S_PREP:  o_cmd.prep     = 1'b1;
            S_CHECK: o_cmd.check    = 1'b1;
            S_LAST:  o_cmd.cap_last = 1'b1;
            S_ISSUE: ;
            S_STEP:  o_cmd.step     = 1'b1;
            S_RSLOT: o_cmd.cap_slot = 1'b1;
            S_DONE:  o_cmd.load_out = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/page_pool_allocator_unit.sv
// Top level of the page pool allocator: free page stack plus per-process bank table.
//
// Input channel (i_in_valid / o_in_stall / i_in_item) takes one action item at a time:
// add page, allocate, free, resize or read slot. Output channel (o_out_valid /
// i_out_stall / o_out_item) returns exactly one result item per action, with the
// status, the slot page, the free count and the memory in use.
// Configuration registers are written over i_cfg_valid / o_cfg_ready; the user must
// write them only while idle, which the block does not enforce; the port is always ready.
// Each accepted item passes the prep and check states; add and rejected actions
// then go to done, read slot passes the slot read state first, and allocate, free
// and resize walk the slots through alternating issue and step states, a shrink
// first capturing the last page. The issue state covers the registered read of the
// table and stack memories. The next item is accepted in the cycle after the
// previous result is loaded into the output register.
// If the receiver stalls, the result holds in the output register; the block still
// accepts and works on the next item and waits only when that result is ready.
// Reset (synchronous, active low) empties the pool, clears the bank table through
// per-entry valid bits and restores the register defaults; no clearing pass is needed.
`default_nettype none

module page_pool_allocator_unit
    import ppa_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES,
    parameter int PROCS     = DEF_PROCS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_item,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ppa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ppa_datapath #(
        .MAX_PAGES (MAX_PAGES),
        .PROCS     (PROCS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // Only one item is in progress at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item accepted while one is in progress");

    // A result appears only through a load from the sequencer.
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.load_out))
        else $error("result valid without a load");

    // A pending result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

    // The slot walk never steps past its end.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> !w_sts.loop_end)
        else $error("slot walk stepped past its end");

endmodule

`default_nettype wire
